/* rtl/core/swept_sphere_collision_test_defines.svh */
// ----------------------------------------------------------------------------
// swept sphere collision test: assertion macros
// shared property forms for the checker of the collision test block
// ----------------------------------------------------------------------------
`ifndef SWEPT_SPHERE_COLLISION_TEST_DEFINES_SVH
`define SWEPT_SPHERE_COLLISION_TEST_DEFINES_SVH

// same-cycle implication, off while reset is high
`define SSCOL_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define SSCOL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also holds across reset
`define SSCOL_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/sscol_pkg.sv */
// ----------------------------------------------------------------------------
// sscol_pkg
// shared types and constants of the swept sphere collision test
// ----------------------------------------------------------------------------
package sscol_pkg;

   // digit width of the split multipliers; a digit plus sign fits 32 bits
   localparam int DIGIT_W = 31;

   localparam int CSR_IDX_W = 3;
   localparam int DEC_W     = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_POS_X,
      REG_POS_Y,
      REG_POS_Z,
      REG_VEL_X,
      REG_VEL_Y,
      REG_VEL_Z,
      REG_RADIUS,
      REG_TIME_STEP
   } csr_reg_type;

   typedef enum logic [DEC_W-1:0] {
      CASE_OVERLAP,
      CASE_SEPARATING,
      CASE_BEYOND,
      CASE_CONTACT,
      CASE_MISS
   } decision_type;

endpackage

/* rtl/core/sscol_req_if.sv */
// ----------------------------------------------------------------------------
// sscol_req_if
// candidate sphere channel: valid, ready and the candidate fields
// ----------------------------------------------------------------------------
interface sscol_req_if
   import sscol_pkg::*;
#(
   parameter int COORD_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] cand_pos_x;
   logic signed [COORD_WIDTH-1:0] cand_pos_y;
   logic signed [COORD_WIDTH-1:0] cand_pos_z;
   logic signed [COORD_WIDTH-1:0] cand_vel_x;
   logic signed [COORD_WIDTH-1:0] cand_vel_y;
   logic signed [COORD_WIDTH-1:0] cand_vel_z;
   logic        [COORD_WIDTH-2:0] cand_radius;

   modport source (
      output valid, cand_pos_x, cand_pos_y, cand_pos_z,
             cand_vel_x, cand_vel_y, cand_vel_z, cand_radius,
      input  ready
   );

   modport sink (
      input  valid, cand_pos_x, cand_pos_y, cand_pos_z,
             cand_vel_x, cand_vel_y, cand_vel_z, cand_radius,
      output ready
   );
endinterface

/* rtl/core/sscol_rsp_if.sv */
// ----------------------------------------------------------------------------
// sscol_rsp_if
// result channel: valid, ready, contact flag and decision case
// ----------------------------------------------------------------------------
interface sscol_rsp_if
   import sscol_pkg::*;
;
   logic             valid;
   logic             ready;
   logic             contact;
   logic [DEC_W-1:0] decision_case;

   modport source (
      output valid, contact, decision_case,
      input  ready
   );

   modport sink (
      input  valid, contact, decision_case,
      output ready
   );
endinterface

/* rtl/core/sscol_mul.sv */
// ----------------------------------------------------------------------------
// sscol_mul
// pipelined signed multiplier: operands split into digits, one digit product
// formed and one accumulated per stage
// ----------------------------------------------------------------------------
module sscol_mul
   import sscol_pkg::*;
#(
   parameter int AW     = 32,
   parameter int BW     = 32,
   parameter int STAGES = 5
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [AW-1:0] a,
   input  logic signed [BW-1:0] b,
   output logic signed [AW+BW-1:0] p
);
   localparam int NA  = (AW + DIGIT_W - 1) / DIGIT_W;
   localparam int NB  = (BW + DIGIT_W - 1) / DIGIT_W;
   localparam int NP  = NA * NB;
   localparam int AXW = NA * DIGIT_W;
   localparam int BXW = NB * DIGIT_W;
   localparam int PW  = AW + BW;
   localparam int DGW = DIGIT_W + 1;
   localparam int PRW = 2 * DGW;

   logic signed [AXW-1:0] a_ext;
   logic signed [BXW-1:0] b_ext;
   logic signed [AXW-1:0] a_ff    [NP];
   logic signed [BXW-1:0] b_ff    [NP];
   logic signed [PRW-1:0] prod_ff [NP];
   logic signed [PW-1:0]  acc_ff  [STAGES];

   assign a_ext = AXW'(a);
   assign b_ext = BXW'(b);

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic signed [PW-1:0] acc_in;

      if (k < NP) begin : g_prod
         localparam int IA = k % NA;
         localparam int IB = k / NA;
         logic signed [AXW-1:0] a_src;
         logic signed [BXW-1:0] b_src;
         logic signed [DGW-1:0] a_dig;
         logic signed [DGW-1:0] b_dig;
         logic signed [PRW-1:0] prod_in;

         if (k == 0) begin : g_first
            assign a_src = a_ext;
            assign b_src = b_ext;
         end else begin : g_next
            assign a_src = a_ff[k-1];
            assign b_src = b_ff[k-1];
         end

         // lower digits are unsigned, the top digit carries the sign
         assign a_dig = $signed({(IA == NA - 1) ? a_src[AXW-1] : 1'b0,
                                 a_src[IA*DIGIT_W +: DIGIT_W]});
         assign b_dig = $signed({(IB == NB - 1) ? b_src[BXW-1] : 1'b0,
                                 b_src[IB*DIGIT_W +: DIGIT_W]});
         assign prod_in = a_dig * b_dig;

         always_ff @(posedge clock) begin
            if (en) begin
               prod_ff[k] <= prod_in;
            end
         end

         if (k < NP - 1) begin : g_carry
            always_ff @(posedge clock) begin
               if (en) begin
                  a_ff[k] <= a_src;
                  b_ff[k] <= b_src;
               end
            end
         end
      end

      if (k == 0) begin : g_acc_first
         assign acc_in = '0;
      end else if (k <= NP) begin : g_acc_add
         localparam int SH = ((k - 1) % NA + (k - 1) / NA) * DIGIT_W;
         assign acc_in = acc_ff[k-1] + (PW'(prod_ff[k-1]) <<< SH);
      end else begin : g_acc_pass
         assign acc_in = acc_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            acc_ff[k] <= acc_in;
         end
      end
   end

   assign p = acc_ff[STAGES-1];

endmodule

/* rtl/core/swept_sphere_collision_test.sv */
// ----------------------------------------------------------------------------
// swept_sphere_collision_test
// contact test of candidate spheres against a moving reference sphere.
// the csr port holds the reference center, velocity, radius and time step;
// write it only while no item is in flight. each item on req_if is one
// candidate sphere and gives exactly one item on rsp_if: a contact flag and
// the decision case (overlap, separating, closest beyond step, contact in
// step, miss). one item is taken every cycle while the skid register is
// empty; the depth is set by the two split product pipelines (digit
// products of about 32 by 32 bits, one accumulated per stage). all stages
// advance together; a result the sink does not take moves into a skid
// register, so one more item is still accepted, after which the pipeline
// holds until the skid drains. reset empties the pipeline and loads the
// registers: all zero, time step 1.0.
// ----------------------------------------------------------------------------
module swept_sphere_collision_test
   import sscol_pkg::*;
#(
   parameter  int COORD_WIDTH = 32,
   parameter  int FRAC_BITS   = 16,
   localparam int CSR_W = (COORD_WIDTH > 8 + FRAC_BITS) ? COORD_WIDTH : 8 + FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   sscol_req_if.sink            req_if,
   sscol_rsp_if.source          rsp_if,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wr_data
);
   localparam int RAD_W  = COORD_WIDTH - 1;
   localparam int TS_W   = 8 + FRAC_BITS;
   localparam int DP_W   = COORD_WIDTH + 1;
   localparam int RS_W   = COORD_WIDTH;
   localparam int VEL_W  = DP_W + TS_W + 1;
   localparam int PSQ_W  = 2 * DP_W;
   localparam int RR_W   = 2 * RS_W;
   localparam int PP_W   = 2 * DP_W + 2;
   localparam int PVM_W  = DP_W + VEL_W;
   localparam int VVM_W  = 2 * VEL_W;
   localparam int PV_W   = PVM_W + 2;
   localparam int VV_W   = VVM_W + 2;
   localparam int C2A_W  = ((PV_W + FRAC_BITS > VV_W) ? PV_W + FRAC_BITS : VV_W) + 1;
   localparam int C2B_T  = (VV_W > PV_W + FRAC_BITS + 1) ? VV_W : PV_W + FRAC_BITS + 1;
   localparam int C2B_W  = ((C2B_T > PP_W + 2 * FRAC_BITS) ? C2B_T : PP_W + 2 * FRAC_BITS) + 2;
   localparam int PPVV_W = PP_W + VV_W;
   localparam int PVPV_W = 2 * PV_W;
   localparam int DIFF_W = ((PPVV_W > PVPV_W) ? PPVV_W : PVPV_W) + 1;

   localparam int ND_DP  = (DP_W + DIGIT_W - 1) / DIGIT_W;
   localparam int ND_VEL = (VEL_W + DIGIT_W - 1) / DIGIT_W;
   localparam int ND_PP  = (PP_W + DIGIT_W - 1) / DIGIT_W;
   localparam int ND_VV  = (VV_W + DIGIT_W - 1) / DIGIT_W;
   localparam int ND_PV  = (PV_W + DIGIT_W - 1) / DIGIT_W;
   localparam int NP_PV  = ND_DP * ND_VEL;
   localparam int NP_VV  = ND_VEL * ND_VEL;
   localparam int NP_A   = ND_PP * ND_VV;
   localparam int NP_B   = ND_PV * ND_PV;
   localparam int ST_S   = ((NP_PV > NP_VV) ? NP_PV : NP_VV) + 1;
   localparam int ST_B   = ((NP_A > NP_B) ? NP_A : NP_B) + 1;

   localparam int G_MUL1 = 3;
   localparam int G_SUM  = G_MUL1 + ST_S;
   localparam int G_MUL2 = G_SUM + 1;
   localparam int G_OUT  = G_MUL2 + ST_B;
   localparam int NSTG   = G_OUT + 1;

   typedef struct packed {
      logic overlap;
      logic separating;
      logic beyond;
   } flags_type;

   // reference sphere and step
   logic signed [COORD_WIDTH-1:0] ref_pos_ff [3];
   logic signed [COORD_WIDTH-1:0] ref_vel_ff [3];
   logic        [RAD_W-1:0]       ref_radius_ff;
   logic        [TS_W-1:0]        time_step_ff;

   logic                pipe_en;
   logic [NSTG-1:0]     v_ff;

   logic signed [COORD_WIDTH-1:0] cand_pos [3];
   logic signed [COORD_WIDTH-1:0] cand_vel [3];

   logic signed [DP_W-1:0]  dp0_in  [3];
   logic signed [DP_W-1:0]  dv0_in  [3];
   logic        [RS_W-1:0]  rsum0_in;
   logic signed [DP_W-1:0]  dp0_ff  [3];
   logic signed [DP_W-1:0]  dv0_ff  [3];
   logic        [RS_W-1:0]  rsum0_ff;

   logic signed [TS_W:0]    ts_s;
   logic signed [VEL_W-1:0] vel1_in [3];
   logic signed [PSQ_W-1:0] psq1_in [3];
   logic        [RR_W-1:0]  rr1_in;
   logic signed [DP_W-1:0]  p1_ff   [3];
   logic signed [VEL_W-1:0] vel1_ff [3];
   logic signed [PSQ_W-1:0] psq1_ff [3];
   logic        [RR_W-1:0]  rr1_ff;

   logic signed [PP_W-1:0]  pp2_in;
   logic signed [DP_W-1:0]  p2_ff   [3];
   logic signed [VEL_W-1:0] vel2_ff [3];
   logic signed [PP_W-1:0]  pp2_ff;

   logic signed [PP_W-1:0]  pp_line_ff [ST_S];
   logic signed [PVM_W-1:0] pvm [3];
   logic signed [VVM_W-1:0] vvm [3];

   logic signed [PV_W-1:0]  pv_s_in;
   logic signed [VV_W-1:0]  vv_s_in;
   logic signed [PP_W-1:0]  pp_s_ff;
   logic signed [PV_W-1:0]  pv_s_ff;
   logic signed [VV_W-1:0]  vv_s_ff;

   logic signed [C2A_W-1:0] c2a;
   logic signed [C2B_W-1:0] c2b;
   flags_type               flags_in;
   flags_type               flags_line_ff [ST_B];
   logic signed [PPVV_W-1:0] ppvv;
   logic signed [PVPV_W-1:0] pvpv;

   logic signed [DIFF_W-1:0] diff;
   logic                     in_step;
   flags_type                flags_out;
   decision_type             case_in;
   logic                     contact_in;
   decision_type             case_ff;
   logic                     contact_ff;

   logic                     skid_v_ff;
   decision_type             skid_case_ff;
   logic                     skid_contact_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            ref_pos_ff[i] <= '0;
            ref_vel_ff[i] <= '0;
         end
         ref_radius_ff <= '0;
         time_step_ff  <= TS_W'(1) << FRAC_BITS;
      end else if (csr_wr_en) begin
         unique case (csr_reg_type'(csr_index))
            REG_POS_X:     ref_pos_ff[0] <= csr_wr_data[COORD_WIDTH-1:0];
            REG_POS_Y:     ref_pos_ff[1] <= csr_wr_data[COORD_WIDTH-1:0];
            REG_POS_Z:     ref_pos_ff[2] <= csr_wr_data[COORD_WIDTH-1:0];
            REG_VEL_X:     ref_vel_ff[0] <= csr_wr_data[COORD_WIDTH-1:0];
            REG_VEL_Y:     ref_vel_ff[1] <= csr_wr_data[COORD_WIDTH-1:0];
            REG_VEL_Z:     ref_vel_ff[2] <= csr_wr_data[COORD_WIDTH-1:0];
            REG_RADIUS:    ref_radius_ff <= csr_wr_data[RAD_W-1:0];
            REG_TIME_STEP: time_step_ff  <= csr_wr_data[TS_W-1:0];
         endcase
      end
   end

   // the whole pipeline moves together unless the skid holds a result
   assign pipe_en      = !skid_v_ff;
   assign req_if.ready = pipe_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (pipe_en) begin
         v_ff <= {v_ff[NSTG-2:0], req_if.valid};
      end
   end

   assign cand_pos[0] = req_if.cand_pos_x;
   assign cand_pos[1] = req_if.cand_pos_y;
   assign cand_pos[2] = req_if.cand_pos_z;
   assign cand_vel[0] = req_if.cand_vel_x;
   assign cand_vel[1] = req_if.cand_vel_y;
   assign cand_vel[2] = req_if.cand_vel_z;

   // relative position, velocity and contact distance
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dp0_in[i] = DP_W'(cand_pos[i]) - DP_W'(ref_pos_ff[i]);
         dv0_in[i] = DP_W'(cand_vel[i]) - DP_W'(ref_vel_ff[i]);
      end
      rsum0_in = RS_W'(req_if.cand_radius) + RS_W'(ref_radius_ff);
   end

   // velocity scaled by the step, squared terms of p and r
   assign ts_s = $signed({1'b0, time_step_ff});

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vel1_in[i] = dv0_ff[i] * ts_s;
         psq1_in[i] = dp0_ff[i] * dp0_ff[i];
      end
      rr1_in = rsum0_ff * rsum0_ff;
   end

   assign pp2_in = PP_W'(psq1_ff[0]) + PP_W'(psq1_ff[1]) + PP_W'(psq1_ff[2])
                   - PP_W'(rr1_ff);

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int i = 0; i < 3; i++) begin
            dp0_ff[i]  <= dp0_in[i];
            dv0_ff[i]  <= dv0_in[i];
            p1_ff[i]   <= dp0_ff[i];
            vel1_ff[i] <= vel1_in[i];
            psq1_ff[i] <= psq1_in[i];
            p2_ff[i]   <= p1_ff[i];
            vel2_ff[i] <= vel1_ff[i];
         end
         rsum0_ff <= rsum0_in;
         rr1_ff   <= rr1_in;
         pp2_ff   <= pp2_in;
         pp_line_ff[0] <= pp2_ff;
         for (int k = 1; k < ST_S; k++) begin
            pp_line_ff[k] <= pp_line_ff[k-1];
         end
      end
   end

   // p.v and v.v, one split multiplier per term
   for (genvar i = 0; i < 3; i++) begin : g_dot
      sscol_mul #(
         .AW     (DP_W),
         .BW     (VEL_W),
         .STAGES (ST_S)
      ) u_pv_mul (
         .clock (clock),
         .en    (pipe_en),
         .a     (p2_ff[i]),
         .b     (vel2_ff[i]),
         .p     (pvm[i])
      );

      sscol_mul #(
         .AW     (VEL_W),
         .BW     (VEL_W),
         .STAGES (ST_S)
      ) u_vv_mul (
         .clock (clock),
         .en    (pipe_en),
         .a     (vel2_ff[i]),
         .b     (vel2_ff[i]),
         .p     (vvm[i])
      );
   end

   assign pv_s_in = PV_W'(pvm[0]) + PV_W'(pvm[1]) + PV_W'(pvm[2]);
   assign vv_s_in = VV_W'(vvm[0]) + VV_W'(vvm[1]) + VV_W'(vvm[2]);

   // early cases; sums aligned to the units of vv
   always_comb begin
      c2a = (C2A_W'(pv_s_ff) <<< FRAC_BITS) + C2A_W'(vv_s_ff);
      c2b = C2B_W'(vv_s_ff) + (C2B_W'(pv_s_ff) <<< (FRAC_BITS + 1))
            + (C2B_W'(pp_s_ff) <<< (2 * FRAC_BITS));
      flags_in.overlap    = pp_s_ff[PP_W-1] || (pp_s_ff == '0);
      flags_in.separating = !pv_s_ff[PV_W-1];
      flags_in.beyond     = (c2a[C2A_W-1] || (c2a == '0)) && !c2b[C2B_W-1];
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         pp_s_ff <= pp_line_ff[ST_S-1];
         pv_s_ff <= pv_s_in;
         vv_s_ff <= vv_s_in;
         flags_line_ff[0] <= flags_in;
         for (int k = 1; k < ST_B; k++) begin
            flags_line_ff[k] <= flags_line_ff[k-1];
         end
      end
   end

   // discriminant products
   sscol_mul #(
      .AW     (PP_W),
      .BW     (VV_W),
      .STAGES (ST_B)
   ) u_ppvv_mul (
      .clock (clock),
      .en    (pipe_en),
      .a     (pp_s_ff),
      .b     (vv_s_ff),
      .p     (ppvv)
   );

   sscol_mul #(
      .AW     (PV_W),
      .BW     (PV_W),
      .STAGES (ST_B)
   ) u_pvpv_mul (
      .clock (clock),
      .en    (pipe_en),
      .a     (pv_s_ff),
      .b     (pv_s_ff),
      .p     (pvpv)
   );

   always_comb begin
      diff      = DIFF_W'(ppvv) - DIFF_W'(pvpv);
      in_step   = diff[DIFF_W-1] || (diff == '0);
      flags_out = flags_line_ff[ST_B-1];
      priority if (flags_out.overlap) begin
         case_in = CASE_OVERLAP;
      end else if (flags_out.separating) begin
         case_in = CASE_SEPARATING;
      end else if (flags_out.beyond) begin
         case_in = CASE_BEYOND;
      end else if (in_step) begin
         case_in = CASE_CONTACT;
      end else begin
         case_in = CASE_MISS;
      end
      contact_in = (case_in == CASE_OVERLAP) || (case_in == CASE_CONTACT);
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         case_ff    <= case_in;
         contact_ff <= contact_in;
      end
   end

   // skid register for a result the sink did not take
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (rsp_if.ready) begin
            skid_v_ff <= 1'b0;
         end
      end else if (v_ff[G_OUT] && !rsp_if.ready) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_v_ff) begin
         skid_case_ff    <= case_ff;
         skid_contact_ff <= contact_ff;
      end
   end

   assign rsp_if.valid         = skid_v_ff || v_ff[G_OUT];
   assign rsp_if.contact       = skid_v_ff ? skid_contact_ff : contact_ff;
   assign rsp_if.decision_case = skid_v_ff ? skid_case_ff : case_ff;

endmodule

/* rtl/core/sscol_checker.sv */
// ----------------------------------------------------------------------------
// sscol_checker
// port-level checks of the swept sphere collision test, bound to the top
// ----------------------------------------------------------------------------
`include "swept_sphere_collision_test_defines.svh"

module sscol_checker
   import sscol_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic             contact,
   input logic [DEC_W-1:0] decision_case
);
   logic req_seen;

   // an item offered while nothing waits at the output is always taken
   assign req_seen = req_valid && !rsp_valid;

   `SSCOL_ASSERT_IMPL(a_contact_matches_case, clock, reset, rsp_valid, contact == ((decision_case == CASE_OVERLAP) || (decision_case == CASE_CONTACT)), "contact flag disagrees with decision case")
   `SSCOL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(contact) && $stable(decision_case), "stalled result changed")
   `SSCOL_ASSERT_IMPL(a_ready_when_drained, clock, reset, req_seen, req_ready, "input stalled with no result waiting")
   `SSCOL_ASSERT_NEXT_ALWAYS(a_reset_empties, clock, reset, !rsp_valid, "result valid right after reset")

endmodule

bind swept_sphere_collision_test sscol_checker u_sscol_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .contact       (rsp_if.contact),
   .decision_case (rsp_if.decision_case)
);
